>>> hdl/wvpd_pkg.sv
// ----------------------------------------------------------------------------
// wvpd_pkg: shared types and constants for the wheel velocity drive
// Register indexes, reset values and fixed controller constants.
// ----------------------------------------------------------------------------
package wvpd_pkg;

	localparam int unsigned VelWidthDefault = 16;
	localparam int unsigned RegCount        = 7;
	localparam int unsigned CfgIdxWidth     = 3;
	localparam int unsigned CfgDataWidth    = 24;

	typedef enum logic [CfgIdxWidth-1:0] {
		REG_KP      = 3'd0,
		REG_KI      = 3'd1,
		REG_KD      = 3'd2,
		REG_UPPER   = 3'd3,
		REG_LOWER   = 3'd4,
		REG_ACCEL   = 3'd5,
		REG_NEUTRAL = 3'd6
	} reg_idx_t;

	localparam logic [7:0]  UpperReset   = 8'd250;
	localparam logic [7:0]  LowerReset   = 8'd0;
	localparam logic [15:0] AccelReset   = 16'd5120;
	localparam logic [7:0]  NeutralReset = 8'd125;

	localparam int unsigned DivWidth = 64;

endpackage

>>> hdl/wheel_velocity_pid_drive.sv
// ----------------------------------------------------------------------------
// wheel_velocity_pid_drive: velocity PID for one wheel with anti-windup
// One request per control tick; one result per request.
// ----------------------------------------------------------------------------
// In closed loop a tick runs a short sequence through one shared 33x33
// multiplier (plausibility product, P, I, D products; the integral update is
// left out when integration is frozen or skipped) plus two passes of a 64-bit
// serial divider for the derivative term (quotient, then remainder scaled by
// 2^16), one bit per cycle. E-stop, open loop and rejected samples skip the
// PID. The input is not ready while a tick is in progress, nor while a
// finished result waits unread in the output register.
module wheel_velocity_pid_drive #(
	parameter int unsigned VELOCITY_WIDTH = wvpd_pkg::VelWidthDefault
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wvpd_pkg::CfgIdxWidth-1:0]    cfg_index,
	input  logic [wvpd_pkg::CfgDataWidth-1:0]   cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// emergency_stop, closed_loop, commanded_velocity, measured_velocity, time_step
	input  logic [((2*VELOCITY_WIDTH+18+7)/8)*8-1:0] s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// motor_command, clamped_high, clamped_low, filtered_velocity, sample_rejected
	output logic [((VELOCITY_WIDTH+11+7)/8)*8-1:0]   m_tdata
);
	import wvpd_pkg::*;

	localparam int unsigned VW  = VELOCITY_WIDTH;
	localparam int unsigned OW  = ((VW+11+7)/8)*8;
	localparam int unsigned AW  = VW + 2;        // widened velocity sums
	localparam int unsigned EW  = VW + 1;        // error and history difference

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_CHECK = 12'b000000000010,
		ST_FILT  = 12'b000000000100,
		ST_P     = 12'b000000001000,
		ST_IMUL  = 12'b000000010000,
		ST_IHI   = 12'b000000100000,
		ST_ILO   = 12'b000001000000,
		ST_DMUL  = 12'b000010000000,
		ST_DQ    = 12'b000100000000,
		ST_DR    = 12'b001000000000,
		ST_SUM   = 12'b010000000000,
		ST_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;

	// configuration
	logic signed [23:0] kp_q, ki_q, kd_q;
	logic [7:0]  upper_q, lower_q, neutral_q;
	logic [15:0] accel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q <= '0; ki_q <= '0; kd_q <= '0;
			upper_q <= UpperReset; lower_q <= LowerReset;
			accel_q <= AccelReset; neutral_q <= NeutralReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP:      kp_q      <= cfg_data;
				REG_KI:      ki_q      <= cfg_data;
				REG_KD:      kd_q      <= cfg_data;
				REG_UPPER:   upper_q   <= cfg_data[7:0];
				REG_LOWER:   lower_q   <= cfg_data[7:0];
				REG_ACCEL:   accel_q   <= cfg_data[15:0];
				REG_NEUTRAL: neutral_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// request fields
	logic              estop_q, closed_q;
	logic signed [VW-1:0] cmd_q, meas_q;
	logic [15:0]       dt_q;

	// controller state
	logic signed [VW-1:0] h0_q, h1_q, h2_q, filt_q;
	logic signed [31:0]   isum_q;
	logic                 frozen_q, rejecting_q;
	logic [23:0]          rtime_q;
	logic [7:0]           held_q;

	// working registers
	logic        rej_q;
	logic signed [63:0] p_q, ipart_q, d_q;
	logic signed [63:0] acc_q;
	logic        dneg_q;
	logic [63:0] dq_q;

	// shared multiplier: signed 33 x 33
	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	assign mprod = ma * mb;
	logic signed [65:0] mprod_s1;

	// divider
	logic        div_start, div_done;
	logic [63:0] div_dividend, div_quot;
	logic [15:0] div_rem;

	wvpd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(dt_q), .done(div_done), .quotient(div_quot), .remainder(div_rem)
	);

	logic        mwait_q;
	logic signed [EW-1:0] err;
	logic signed [EW-1:0] hdiff;
	logic [EW-1:0] dv;
	logic [24:0] tsum;
	logic [23:0] tsat;
	logic signed [AW+1:0] hsum;
	logic signed [VW-1:0] fnew;

	assign err   = EW'(cmd_q) - EW'(filt_q);
	assign hdiff = EW'(h0_q) - EW'(h1_q);
	always_comb begin
		logic signed [EW-1:0] dd;
		dd = EW'(meas_q) - EW'(h0_q);
		dv = dd[EW-1] ? EW'(-dd) : dd;
	end
	assign tsum = rejecting_q ? ({1'b0, rtime_q} + 25'(dt_q)) : 25'(dt_q);
	assign tsat = tsum[24] ? 24'hFFFFFF : tsum[23:0];
	assign hsum = (AW+2)'(meas_q) + ((AW+2)'(h0_q) <<< 1) + (AW+2)'(h1_q) + (AW+2)'(2);
	assign fnew = VW'(hsum >>> 2);

	always_comb begin
		ma = '0; mb = '0;
		unique case (state_q)
			ST_CHECK: begin ma = 33'(accel_q); mb = 33'(tsat); end
			ST_P:     begin ma = 33'(kp_q);    mb = 33'(err); end
			ST_IMUL:  begin ma = 33'(ki_q);    mb = 33'(err); end
			ST_IHI:   begin ma = 33'(acc_q >>> 24); mb = 33'(dt_q); end
			ST_ILO:   begin ma = {9'd0, acc_q[23:0]}; mb = 33'(dt_q); end
			ST_DMUL:  begin ma = 33'(kd_q);    mb = 33'(hdiff); end
			default: ;
		endcase
	end

	// output clamp
	logic signed [63:0] pid;
	logic signed [63:0] rnd;
	logic hi_c, lo_c;
	logic [7:0] motor_c;
	always_comb begin
		logic signed [63:0] dr;
		logic signed [63:0] x;
		pid = p_q + (64'(isum_q) <<< 8) + d_q;
		if (!closed_q) x = 64'(cmd_q) * 64'sd50 + (64'(neutral_q) <<< 8);
		else x = pid + (64'sd125 <<< 20);
		if (!closed_q) rnd = x[63] ? -((-x + 64'sd128) >>> 8) : ((x + 64'sd128) >>> 8);
		else rnd = x[63] ? -((-x + (64'sd1 <<< 19)) >>> 20) : ((x + (64'sd1 <<< 19)) >>> 20);
		dr = (closed_q && rejecting_q) ? 64'(held_q) : rnd;
		hi_c = 1'b0; lo_c = 1'b0;
		if (dr > $signed(64'(upper_q))) begin dr = 64'(upper_q); hi_c = 1'b1; end
		if (dr < $signed(64'(lower_q))) begin dr = 64'(lower_q); lo_c = 1'b1; end
		motor_c = dr[7:0];
	end

	logic quiet;
	always_comb begin
		logic signed [AW:0] a0, a1, a2;
		logic [AW:0] s;
		a0 = (AW+1)'(h0_q);
		a1 = (AW+1)'(h1_q);
		a2 = (AW+1)'(h2_q);
		a0 = a0[AW] ? -a0 : a0;
		a1 = a1[AW] ? -a1 : a1;
		a2 = a2[AW] ? -a2 : a2;
		s = $unsigned(a0 + a1 + a2);
		quiet = (s * (AW+8)'(100)) < (AW+8)'(2304);
	end

	logic [OW-1:0] tdata_q;
	logic          ovalid_q;
	assign s_tready = (state_q == ST_IDLE) && !(ovalid_q && !m_tready);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = tdata_q;

	always_ff @(posedge clk) mprod_s1 <= mprod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovalid_q <= 1'b0;
			h0_q <= '0; h1_q <= '0; h2_q <= '0; filt_q <= '0;
			isum_q <= '0; frozen_q <= 1'b0; rejecting_q <= 1'b0; rtime_q <= '0;
			held_q <= NeutralReset;
			mwait_q <= 1'b0;
			div_start <= 1'b0;
		end else begin
			div_start <= 1'b0;
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					estop_q  <= s_tdata[0];
					closed_q <= s_tdata[1];
					cmd_q    <= s_tdata[2 +: VW];
					meas_q   <= s_tdata[2+VW +: VW];
					dt_q     <= (s_tdata[2+2*VW +: 16] == 16'd0) ? 16'd1 : s_tdata[2+2*VW +: 16];
					p_q <= '0; d_q <= '0;
					mwait_q <= 1'b0;
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					mwait_q <= ~mwait_q;
					if (mwait_q) begin
						rtime_q <= tsat;
						rej_q <= ((66'(dv) <<< 16) > mprod_s1);
						rejecting_q <= ((66'(dv) <<< 16) > mprod_s1);
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					if (!rej_q) begin
						h2_q <= h1_q; h1_q <= h0_q; h0_q <= fnew; filt_q <= fnew;
					end
					state_q <= ST_SUM;
					if (!estop_q && cmd_q == '0) isum_q <= '0;
					if (!estop_q && closed_q && !rej_q) state_q <= ST_P;
				end
				ST_P: begin
					mwait_q <= ~mwait_q;
					if (mwait_q) begin p_q <= 64'(mprod_s1); state_q <= ST_IMUL; end
				end
				ST_IMUL: begin
					mwait_q <= ~mwait_q;
					if (mwait_q) begin
						acc_q <= 64'(mprod_s1);
						// a quiet stop keeps the integral cleared
						state_q <= (frozen_q || (cmd_q == '0 && quiet)) ? ST_DMUL : ST_IHI;
					end
				end
				ST_IHI: begin
					mwait_q <= ~mwait_q;
					if (mwait_q) begin ipart_q <= 64'(mprod_s1); state_q <= ST_ILO; end
				end
				ST_ILO: begin
					mwait_q <= ~mwait_q;
					if (mwait_q) begin
						logic signed [63:0] ns;
						ns = 64'(isum_q) + ipart_q + (64'(mprod_s1) >>> 24);
						if (ns > 64'sd2147483647) isum_q <= 32'sh7FFFFFFF;
						else if (ns < -64'sd2147483648) isum_q <= 32'sh80000000;
						else isum_q <= ns[31:0];
						state_q <= ST_DMUL;
					end
				end
				ST_DMUL: begin
					mwait_q <= ~mwait_q;
					if (mwait_q) begin
						dneg_q <= mprod_s1[65];
						div_dividend <= mprod_s1[65] ? 64'(-mprod_s1) : 64'(mprod_s1);
						div_start <= 1'b1;
						state_q <= ST_DQ;
					end
				end
				ST_DQ: if (div_done) begin
					dq_q <= div_quot;
					div_dividend <= 64'(div_rem) << 16;
					div_start <= 1'b1;
					state_q <= ST_DR;
				end
				ST_DR: if (div_done) begin
					if (dq_q >= (64'd1 << 44)) d_q <= dneg_q ? -(64'sd1 <<< 60) : (64'sd1 <<< 60);
					else d_q <= dneg_q ? -64'((dq_q << 16) + div_quot)
						: 64'((dq_q << 16) + div_quot);
					state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_OUT;
				ST_OUT: begin
					logic [7:0] mc;
					logic hf, lf;
					logic [OW-1:0] td;
					mc = motor_c; hf = hi_c; lf = lo_c;
					if (closed_q && !rej_q && !estop_q && !(cmd_q == '0 && quiet)) begin
						frozen_q <= ((pid[63] ? -pid : pid) > (64'sd125 <<< 20));
					end
					if (estop_q) begin
						h0_q <= '0; h1_q <= '0; h2_q <= '0; filt_q <= '0;
						isum_q <= '0; frozen_q <= 1'b0; rejecting_q <= 1'b0; rtime_q <= '0;
						held_q <= neutral_q;
						mc = neutral_q; hf = 1'b0; lf = 1'b0;
					end else if (cmd_q == '0 && quiet) begin
						mc = neutral_q; hf = 1'b0; lf = 1'b0;
					end else begin
						held_q <= motor_c;
					end
					td = '0;
					td[7:0]      = mc;
					td[8]        = hf;
					td[9]        = lf;
					td[10 +: VW] = estop_q ? '0 : filt_q;
					td[10+VW]    = rej_q;
					tdata_q <= td;
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// no new request while a result is outstanding and unread
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready) else $error("ready during stall");
	// a result only follows the output step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_OUT)) else $error("stray result");
	// the sequencer stays one-hot
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
`endif

endmodule

>>> hdl/wvpd_div.sv
// ----------------------------------------------------------------------------
// wvpd_div: serial unsigned divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvpd_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [wvpd_pkg::DivWidth-1:0]  dividend,
	input  logic [15:0]                    divisor,
	output logic                           done,
	output logic [wvpd_pkg::DivWidth-1:0]  quotient,
	output logic [15:0]                    remainder
);
	import wvpd_pkg::*;

	localparam int unsigned CntWidth = $clog2(DivWidth + 1);

	logic [DivWidth-1:0] quo_q;
	logic [16:0]         rem_q;
	logic [15:0]         dsr_q;
	logic [CntWidth-1:0] cnt_q;
	logic                busy_q;
	logic [16:0]         trial;

	always_comb begin
		trial = {rem_q[15:0], quo_q[DivWidth-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntWidth'(DivWidth);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				quo_q <= {quo_q[DivWidth-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DivWidth-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q[15:0];

endmodule

>>> tb/wheel_velocity_pid_drive_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wheel_velocity_pid_drive_tb: self-checking bench for the wheel velocity PID
// Ticks stream in under random back-pressure. Each one is run through a local
// model of the filter, PID and clamp, and every result is checked against it.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module wheel_velocity_pid_drive_tb;

	import wvpd_pkg::*;

	localparam int VW = 16;

	typedef enum {ACT_TICK, ACT_CFG, ACT_DRAIN, ACT_HOLD} act_kind_t;

	typedef struct {
		act_kind_t         kind;
		bit                estop;
		bit                closed;
		logic signed [15:0] cmd;
		logic signed [15:0] meas;
		logic [15:0]       dt;
		int                gap;
		reg_idx_t          idx;
		logic [23:0]       value;
	} action_t;

	typedef struct {
		logic [7:0]        motor;
		bit                hi;
		bit                lo;
		logic [15:0]       filt;
		bit                rej;
	} drive_res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CfgIdxWidth-1:0] cfg_index = '0;
	logic [CfgDataWidth-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [55:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [31:0] m_tdata;

	wheel_velocity_pid_drive #(.VELOCITY_WIDTH(VW)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	action_t    pending[$];
	drive_res_t drive_expect[$];
	int         errs = 0;

	// model copy of registers and state
	logic [23:0] kp_reg = '0, ki_reg = '0, kd_reg = '0;
	logic [7:0]  upper_reg = UpperReset, lower_reg = LowerReset, neutral_reg = NeutralReset;
	logic [15:0] accel_reg = AccelReset;
	longint      hist[3] = '{0, 0, 0};
	longint      last_filt = 0, integ = 0;
	bit          frozen = 0, rejecting = 0;
	longint      rej_time = 0;
	logic [7:0]  held = 8'd125;

	function automatic longint round_shr(longint x, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (x >= 0)
			return (x + half) >>> s;
		return -((-x + half) >>> s);
	endfunction

	function automatic longint mag(longint x);
		return (x < 0) ? -x : x;
	endfunction

	task automatic clear_loop();
		hist = '{0, 0, 0};
		last_filt = 0;
		integ = 0;
		frozen = 0;
		rejecting = 0;
		rej_time = 0;
	endtask

	task automatic predict_tick(input action_t t, output drive_res_t r);
		longint cmd, meas, dt, tsum, dv, e, p, a, ah, al, ns, dsum, q, rm, d, pid, drive, f;
		longint kp, ki, kd;
		bit quiet;
		cmd = longint'(t.cmd);
		meas = longint'(t.meas);
		kp = longint'($signed(kp_reg));
		ki = longint'($signed(ki_reg));
		kd = longint'($signed(kd_reg));
		dt = (t.dt == 0) ? 1 : longint'(t.dt);
		r.hi = 0;
		r.lo = 0;

		tsum = rejecting ? rej_time + dt : dt;
		if (tsum > 64'hFFFFFF) tsum = 64'hFFFFFF;
		rej_time = tsum;
		dv = mag(meas - hist[0]);
		r.rej = (dv << 16) > longint'(accel_reg) * tsum;
		rejecting = r.rej;
		if (!r.rej) begin
			f = (meas + 2 * hist[0] + hist[1] + 2) >>> 2;
			hist[2] = hist[1];
			hist[1] = hist[0];
			hist[0] = f;
			last_filt = f;
		end

		if (t.estop) begin
			clear_loop();
			held = neutral_reg;
			r.motor = neutral_reg;
		end else begin
			quiet = 0;
			if (cmd == 0) begin
				integ = 0;
				quiet = (mag(hist[0]) + mag(hist[1]) + mag(hist[2])) * 100 < 2304;
			end
			if (quiet) begin
				r.motor = neutral_reg;
			end else begin
				drive = held;
				if (t.closed) begin
					if (!rejecting) begin
						e = cmd - last_filt;
						p = kp * e;
						a = ki * e;
						if (!frozen) begin
							ah = a >>> 24;
							al = a - (ah <<< 24);
							ns = integ + ah * dt + ((al * dt) >>> 24);
							if (ns > 64'sd2147483647) ns = 64'sd2147483647;
							if (ns < -64'sd2147483648) ns = -64'sd2147483648;
							integ = ns;
						end
						dsum = kd * (hist[0] - hist[1]);
						q = dsum / dt;
						rm = dsum % dt;
						if (q >= (longint'(1) << 44)) d = longint'(1) << 60;
						else if (q <= -(longint'(1) << 44)) d = -(longint'(1) << 60);
						else d = q * 65536 + (rm * 65536) / dt;
						pid = p + integ * 256 + d;
						frozen = mag(pid) > (longint'(125) << 20);
						drive = round_shr(pid + (longint'(125) << 20), 20);
					end
				end else begin
					drive = round_shr(cmd * 50 + longint'(neutral_reg) * 256, 8);
				end
				if (drive > longint'(upper_reg)) begin
					drive = upper_reg;
					r.hi = 1;
				end
				if (drive < longint'(lower_reg)) begin
					drive = lower_reg;
					r.lo = 1;
				end
				held = drive[7:0];
				r.motor = held;
			end
		end
		r.filt = last_filt[15:0];
	endtask

	// handshake flags passed from the sampling edge to the driving edge
	bit s_taken = 0, m_taken = 0, hold_req = 0;

	always @(posedge clk) begin
		drive_res_t got, want;
		if (arst_n) begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_KP:      kp_reg = cfg_data;
					REG_KI:      ki_reg = cfg_data;
					REG_KD:      kd_reg = cfg_data;
					REG_UPPER:   upper_reg = cfg_data[7:0];
					REG_LOWER:   lower_reg = cfg_data[7:0];
					REG_ACCEL:   accel_reg = cfg_data[15:0];
					REG_NEUTRAL: neutral_reg = cfg_data[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				action_t t;
				t.estop = s_tdata[0];
				t.closed = s_tdata[1];
				t.cmd = s_tdata[17:2];
				t.meas = s_tdata[33:18];
				t.dt = s_tdata[49:34];
				predict_tick(t, want);
				drive_expect.push_back(want);
				s_taken = 1;
			end
			if (m_tvalid && m_tready) begin
				m_taken = 1;
				got.motor = m_tdata[7:0];
				got.hi = m_tdata[8];
				got.lo = m_tdata[9];
				got.filt = m_tdata[25:10];
				got.rej = m_tdata[26];
				if (drive_expect.size() == 0) begin
					$error("result with nothing outstanding: %h", m_tdata);
					errs++;
				end else begin
					want = drive_expect.pop_front();
					if (got.motor !== want.motor) begin
						$error("motor_command expected %0d got %0d", want.motor, got.motor);
						errs++;
					end
					if (got.hi !== want.hi) begin
						$error("clamped_high expected %0d got %0d", want.hi, got.hi);
						errs++;
					end
					if (got.lo !== want.lo) begin
						$error("clamped_low expected %0d got %0d", want.lo, got.lo);
						errs++;
					end
					if (got.filt !== want.filt) begin
						$error("filtered_velocity expected %0d got %0d",
							$signed(want.filt), $signed(got.filt));
						errs++;
					end
					if (got.rej !== want.rej) begin
						$error("sample_rejected expected %0d got %0d", want.rej, got.rej);
						errs++;
					end
				end
			end
		end
	end

	// request driver
	int send_gap = 0, settle = 0;
	always @(negedge clk) begin
		bit nv, nwe;
		logic [55:0] nd;
		logic [CfgIdxWidth-1:0] ni;
		logic [CfgDataWidth-1:0] ncd;
		action_t a;
		nv = s_tvalid;
		nd = s_tdata;
		nwe = 0;
		ni = cfg_index;
		ncd = cfg_data;
		if (arst_n) begin
			if (s_tvalid && s_taken) nv = 0;
			s_taken = 0;
			if (!nv && drive_expect.size() == 0) settle++;
			else settle = 0;
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending.size() > 0) begin
					a = pending[0];
					case (a.kind)
						ACT_TICK: begin
							nv = 1;
							nd = {6'b0, a.dt, a.meas, a.cmd, a.closed, a.estop};
							send_gap = a.gap;
							void'(pending.pop_front());
						end
						ACT_CFG: if (settle >= 100) begin
							nwe = 1;
							ni = a.idx;
							ncd = a.value;
							void'(pending.pop_front());
						end
						ACT_DRAIN: if (drive_expect.size() == 0)
							void'(pending.pop_front());
						ACT_HOLD: begin
							hold_req = 1;
							void'(pending.pop_front());
						end
					endcase
				end
			end
		end
		s_tvalid <= nv;
		s_tdata <= nd;
		cfg_we <= nwe;
		cfg_index <= ni;
		cfg_data <= ncd;
	end

	// result receiver
	int hold_cnt = 0, rx_stall = 0, results_seen = 0;
	always @(negedge clk) begin
		bit rdy;
		rdy = 0;
		if (arst_n) begin
			if (hold_req) begin
				hold_req = 0;
				hold_cnt = 600;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
			end else begin
				if (m_taken) begin
					m_taken = 0;
					results_seen++;
					rx_stall = ((results_seen / 64) % 3 == 0) ? 0 : $urandom_range(0, 16);
				end
				if (rx_stall > 0) rx_stall--;
				else rdy = 1;
			end
		end
		m_tready <= rdy;
	end

	task automatic add_tick(bit es, bit cl, logic [15:0] c, logic [15:0] m,
			logic [15:0] d, int g);
		action_t a;
		a.kind = ACT_TICK;
		a.estop = es;
		a.closed = cl;
		a.cmd = c;
		a.meas = m;
		a.dt = d;
		a.gap = g;
		pending.push_back(a);
	endtask

	task automatic add_cfg(reg_idx_t i, logic [23:0] v);
		action_t a;
		a.kind = ACT_CFG;
		a.idx = i;
		a.value = v;
		pending.push_back(a);
	endtask

	task automatic add_marker(act_kind_t k);
		action_t a;
		a.kind = k;
		pending.push_back(a);
	endtask

	// mostly plausible measurement tracks with random content, some noise
	task automatic add_random_ticks(int n, bit with_hold);
		int mv, g, sel;
		logic [15:0] c, m, d;
		bit es, cl;
		mv = 0;
		for (int k = 0; k < n; k++) begin
			if (with_hold && k == 10) add_marker(ACT_HOLD);
			if (k == n / 2) add_marker(ACT_DRAIN);
			mv += int'($urandom_range(0, 80)) - 40;
			if (mv > 8000) mv = 8000;
			if (mv < -8000) mv = -8000;
			m = 16'(mv + int'($urandom_range(0, 8)) - 4);
			if ($urandom_range(0, 19) == 0) m = 16'($urandom);
			sel = $urandom_range(0, 15);
			if (sel < 2) c = 16'd0;
			else if (sel == 2) c = 16'($urandom);
			else c = 16'(int'($urandom_range(0, 6000)) - 3000);
			sel = $urandom_range(0, 15);
			if (sel == 0) d = 16'd0;
			else if (sel < 3) d = 16'($urandom);
			else d = 16'($urandom_range(300, 7000));
			es = ($urandom_range(0, 39) == 0);
			cl = ($urandom_range(0, 3) != 0);
			if (with_hold && k >= 10 && k < 40) g = 0;
			else g = (k % 100 < 30) ? 0 : $urandom_range(0, 16);
			add_tick(es, cl, c, m, d, g);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings: feed-through extremes, e-stop, quiet stop, zero step, rejection
		add_tick(1'b0, 1'b0, 16'sh7FFF, 16'd0, 16'd655, 3);
		add_tick(1'b0, 1'b0, 16'sh8000, 16'd0, 16'd655, 0);
		add_tick(1'b0, 1'b0, 16'd256, 16'd0, 16'd0, 0);
		add_tick(1'b0, 1'b0, 16'h0000, 16'd0, 16'd655, 2);
		add_tick(1'b1, 1'b1, 16'd500, 16'd20, 16'd655, 0);
		add_tick(1'b0, 1'b1, 16'd500, 16'sh7FFF, 16'd1, 0);
		add_tick(1'b0, 1'b1, 16'd500, 16'sh8000, 16'd0, 1);
		add_tick(1'b0, 1'b1, 16'd500, 16'sh7FFF, 16'hFFFF, 0);
		add_tick(1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF, 0);
		add_tick(1'b0, 1'b1, 16'd0, 16'd0, 16'd655, 0);
		add_marker(ACT_DRAIN);

		// PID with gains, crossed limits
		add_cfg(REG_KP, 24'd163840);
		add_cfg(REG_KI, 24'd81920);
		add_cfg(REG_KD, 24'd8192);
		add_cfg(REG_UPPER, 24'd60);
		add_cfg(REG_LOWER, 24'd100);
		add_cfg(REG_NEUTRAL, 24'd80);
		add_tick(1'b0, 1'b1, 16'd2560, 16'd100, 16'd655, 0);
		add_tick(1'b0, 1'b1, 16'sh8000, 16'd150, 16'd0, 0);
		add_tick(1'b0, 1'b0, 16'd300, 16'd200, 16'd655, 4);
		add_tick(1'b0, 1'b1, 16'd0, 16'd210, 16'd655, 0);
		add_tick(1'b0, 1'b1, 16'sh7FFF, 16'sh8000, 16'd3, 0);

		for (int ph = 0; ph < 8; ph++) begin
			add_marker(ACT_DRAIN);
			case (ph)
				0: begin
					add_cfg(REG_KP, 24'd163840); add_cfg(REG_KI, 24'd81920);
					add_cfg(REG_KD, 24'd8192); add_cfg(REG_UPPER, 24'd250);
					add_cfg(REG_LOWER, 24'd0); add_cfg(REG_ACCEL, 24'd5120);
					add_cfg(REG_NEUTRAL, 24'd125);
				end
				1: begin
					add_cfg(REG_KP, 24'h7FFFFF); add_cfg(REG_KI, 24'h7FFFFF);
					add_cfg(REG_KD, 24'h7FFFFF); add_cfg(REG_UPPER, 24'd255);
					add_cfg(REG_LOWER, 24'd0); add_cfg(REG_ACCEL, 24'hFFFF);
					add_cfg(REG_NEUTRAL, 24'd255);
				end
				2: begin
					add_cfg(REG_KP, 24'h800000); add_cfg(REG_KI, 24'h800000);
					add_cfg(REG_KD, 24'h800000); add_cfg(REG_UPPER, 24'd0);
					add_cfg(REG_LOWER, 24'd255); add_cfg(REG_ACCEL, 24'd0);
					add_cfg(REG_NEUTRAL, 24'd0);
				end
				default: begin
					add_cfg(REG_KP, 24'($urandom_range(0, 24'h7FFFFF)
						- ((ph % 2) ? 24'h200000 : 24'h0)));
					add_cfg(REG_KI, 24'($urandom));
					add_cfg(REG_KD, 24'($urandom_range(0, 24'h0FFFFF)));
					add_cfg(REG_UPPER, 24'($urandom_range(128, 255)));
					add_cfg(REG_LOWER, 24'($urandom_range(0, 127)));
					add_cfg(REG_ACCEL, 24'($urandom_range(1000, 20000)));
					add_cfg(REG_NEUTRAL, 24'($urandom_range(0, 255)));
				end
			endcase
			add_random_ticks(165, ph == 1 || ph == 5);
		end

		do @(posedge clk);
		while (!(pending.size() == 0 && !s_tvalid && drive_expect.size() == 0));
		repeat (200) @(posedge clk);
		if (drive_expect.size() != 0) begin
			$error("%0d results never arrived", drive_expect.size());
			errs++;
		end
		if (errs == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

>>> sim.f
hdl/wvpd_pkg.sv
hdl/wvpd_div.sv
hdl/wheel_velocity_pid_drive.sv
tb/wheel_velocity_pid_drive_tb.sv
